@@ src/segment_polygon_intersection_macros.svh @@
// Assertion helpers shared by the RTL files. Every module that asserts has
// i_clk and i_rst_n, and checks are off while reset is held.
`ifndef SEGMENT_POLYGON_INTERSECTION_MACROS_SVH
`define SEGMENT_POLYGON_INTERSECTION_MACROS_SVH

// Generic property checked at each rising edge outside reset.
`define SPI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition in this cycle implies a consequence in the next cycle.
`define SPI_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (conseq)) else $error(msg);

`endif

@@ src/spi_pkg.sv @@
package spi_pkg;

    localparam int COORD_WIDTH = 16;

    // Input stream: six coordinates packed from the lowest bit, padded to bytes.
    localparam int IN_W  = ((6 * COORD_WIDTH + 7) / 8) * 8;
    // Output stream: one flag padded to a byte.
    localparam int OUT_W = 8;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    // One edge test: edge A-B against query segment S-E.
    typedef struct packed {
        t_coord ax;
        t_coord az;
        t_coord bx;
        t_coord bz;
        t_coord sx;
        t_coord sz;
        t_coord ex;
        t_coord ez;
        logic   emit;
    } t_job;

endpackage

@@ src/spi_front.sv @@
module spi_front
    import spi_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    // Fields from bit 0 up: seg_start_x, seg_start_z, seg_end_x, seg_end_z,
    // vertex_x, vertex_z, zero padding.
    input  logic [IN_W-1:0] i_s_tdata,
    input  logic            i_s_tlast,
    output logic            o_q_valid,
    input  logic            i_q_ready,
    output t_job            o_q_job
);

    localparam int CW = COORD_WIDTH;

    logic   r_open;
    logic   r_pend;
    t_job   r_pend_job;
    t_coord r_first_x, r_first_z;
    t_coord r_prev_x, r_prev_z;
    t_coord r_sx, r_sz, r_ex, r_ez;

    t_coord w_in_sx, w_in_sz, w_in_ex, w_in_ez, w_vx, w_vz;
    logic   w_accept;
    logic   w_has_job;
    t_job   w_job;

    assign w_in_sx = t_coord'(i_s_tdata[0*CW +: CW]);
    assign w_in_sz = t_coord'(i_s_tdata[1*CW +: CW]);
    assign w_in_ex = t_coord'(i_s_tdata[2*CW +: CW]);
    assign w_in_ez = t_coord'(i_s_tdata[3*CW +: CW]);
    assign w_vx    = t_coord'(i_s_tdata[4*CW +: CW]);
    assign w_vz    = t_coord'(i_s_tdata[5*CW +: CW]);

    assign o_s_tready = !r_pend && i_q_ready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_has_job  = r_open || i_s_tlast;

    always_comb begin
        if (r_open) begin
            // Edge from the previous vertex; a closing edge follows if last.
            w_job = '{ax: r_prev_x, az: r_prev_z, bx: w_vx, bz: w_vz,
                      sx: r_sx, sz: r_sz, ex: r_ex, ez: r_ez, emit: 1'b0};
        end else begin
            // A polygon of one vertex tests that vertex against itself.
            w_job = '{ax: w_vx, az: w_vz, bx: w_vx, bz: w_vz,
                      sx: w_in_sx, sz: w_in_sz, ex: w_in_ex, ez: w_in_ez,
                      emit: 1'b1};
        end
    end

    assign o_q_valid = r_pend || (w_accept && w_has_job);
    assign o_q_job   = r_pend ? r_pend_job : w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            if (r_pend && i_q_ready) begin
                r_pend <= 1'b0;
            end
            if (w_accept) begin
                r_open <= !i_s_tlast;
                if (r_open && i_s_tlast) begin
                    r_pend <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prev_x <= w_vx;
            r_prev_z <= w_vz;
            if (!r_open) begin
                r_first_x <= w_vx;
                r_first_z <= w_vz;
                r_sx      <= w_in_sx;
                r_sz      <= w_in_sz;
                r_ex      <= w_in_ex;
                r_ez      <= w_in_ez;
            end
            r_pend_job <= '{ax: w_vx, az: w_vz, bx: r_first_x, bz: r_first_z,
                           sx: r_sx, sz: r_sz, ex: r_ex, ez: r_ez, emit: 1'b1};
        end
    end

`include "segment_polygon_intersection_macros.svh"

    `SPI_ASSERT(a_pend_blocks_input, r_pend |-> !o_s_tready, "input taken with closing edge pending")
    `SPI_ASSERT(a_pend_is_closing, r_pend |-> r_pend_job.emit, "pending edge does not close polygon")
    `SPI_ASSERT_NEXT(a_last_opens_pend, w_accept && i_s_tlast && r_open, r_pend, "closing edge lost")

endmodule

@@ src/spi_fifo.sv @@
module spi_fifo
    import spi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_ready,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_do_push, w_do_pop;

    assign o_ready   = (r_count != QCNT_W'(QDEPTH));
    assign o_valid   = (r_count != '0);
    assign o_job     = r_mem[r_rd_ptr];
    assign w_do_push = i_push && o_ready;
    assign w_do_pop  = i_pop && o_valid;

    function automatic logic [QPTR_W-1:0] f_next(input logic [QPTR_W-1:0] p);
        f_next = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (w_do_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

@@ src/spi_back.sv @@
module spi_back
    import spi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    output logic             o_q_pop,
    input  t_job             i_q_job,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // Fields from bit 0 up: intersects, zero padding.
    output logic [OUT_W-1:0] o_m_tdata
);

    localparam int CW      = COORD_WIDTH;
    localparam int DIFF_W  = CW + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [2:0] STEP_LAST = 3'd4;

    logic [1:0]                r_state;
    logic [2:0]                r_step;
    t_job                      r_job;
    logic signed [PROD_W-1:0]  r_pa, r_pb;
    logic [3:0]                r_neg, r_zero;
    logic                      r_acc;
    logic                      r_m_valid;
    logic                      r_m_hit;

    t_coord                    w_px, w_pz, w_qx, w_qz, w_rx, w_rz;
    logic signed [DIFF_W-1:0]  w_dqx, w_dqz, w_drx, w_drz;
    logic signed [CROSS_W-1:0] w_cross;
    logic [1:0]                w_sidx;
    logic                      w_proper, w_touch, w_edge_hit;
    logic                      w_out_free, w_fire;

    function automatic logic f_between(input t_coord p, input t_coord q, input t_coord r);
        f_between = (r >= p || r >= q) && (r <= p || r <= q);
    endfunction

    // Orientations in order: edge vs segment start, edge vs segment end,
    // segment vs edge start, segment vs edge end.
    always_comb begin
        case (r_step[1:0])
            2'd0: begin
                w_px = r_job.ax; w_pz = r_job.az; w_qx = r_job.bx; w_qz = r_job.bz;
                w_rx = r_job.sx; w_rz = r_job.sz;
            end
            2'd1: begin
                w_px = r_job.ax; w_pz = r_job.az; w_qx = r_job.bx; w_qz = r_job.bz;
                w_rx = r_job.ex; w_rz = r_job.ez;
            end
            2'd2: begin
                w_px = r_job.sx; w_pz = r_job.sz; w_qx = r_job.ex; w_qz = r_job.ez;
                w_rx = r_job.ax; w_rz = r_job.az;
            end
            default: begin
                w_px = r_job.sx; w_pz = r_job.sz; w_qx = r_job.ex; w_qz = r_job.ez;
                w_rx = r_job.bx; w_rz = r_job.bz;
            end
        endcase
    end

    assign w_dqx = DIFF_W'(w_qx) - DIFF_W'(w_px);
    assign w_dqz = DIFF_W'(w_qz) - DIFF_W'(w_pz);
    assign w_drx = DIFF_W'(w_rx) - DIFF_W'(w_px);
    assign w_drz = DIFF_W'(w_rz) - DIFF_W'(w_pz);

    assign w_cross = CROSS_W'(r_pa) - CROSS_W'(r_pb);
    // The products in r_pa and r_pb belong to the orientation one step back.
    assign w_sidx  = r_step[1:0] - 2'd1;

    assign w_proper = !r_zero[0] && !r_zero[1] && (r_neg[0] != r_neg[1]) &&
                      !r_zero[2] && !r_zero[3] && (r_neg[2] != r_neg[3]);

    assign w_touch =
        (r_zero[0] && f_between(r_job.ax, r_job.bx, r_job.sx) &&
                      f_between(r_job.az, r_job.bz, r_job.sz)) ||
        (r_zero[1] && f_between(r_job.ax, r_job.bx, r_job.ex) &&
                      f_between(r_job.az, r_job.bz, r_job.ez)) ||
        (r_zero[2] && f_between(r_job.sx, r_job.ex, r_job.ax) &&
                      f_between(r_job.sz, r_job.ez, r_job.az)) ||
        (r_zero[3] && f_between(r_job.sx, r_job.ex, r_job.bx) &&
                      f_between(r_job.sz, r_job.ez, r_job.bz));

    assign w_edge_hit = w_proper || w_touch;
    assign w_out_free = !r_m_valid || i_m_tready;
    assign w_fire     = (r_state == ST_DONE) && (!r_job.emit || w_out_free);
    assign o_q_pop    = (r_state == ST_IDLE) && i_q_valid;

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{(OUT_W-1){1'b0}}, r_m_hit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= '0;
            r_acc     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            // A new result taking the register keeps it valid.
            if (r_m_valid && i_m_tready && !(w_fire && r_job.emit)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= ST_RUN;
                        r_step  <= '0;
                    end
                end
                ST_RUN: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_LAST) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_fire) begin
                        r_state <= ST_IDLE;
                        if (r_job.emit) begin
                            r_m_valid <= 1'b1;
                            r_acc     <= 1'b0;
                        end else begin
                            r_acc <= r_acc || w_edge_hit;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_q_job;
        end
        if (r_state == ST_RUN) begin
            r_pa <= PROD_W'(w_dqx) * PROD_W'(w_drz);
            r_pb <= PROD_W'(w_dqz) * PROD_W'(w_drx);
            if (r_step != '0) begin
                r_neg[w_sidx]  <= w_cross[CROSS_W-1];
                r_zero[w_sidx] <= (w_cross == '0);
            end
        end
        if (w_fire && r_job.emit) begin
            r_m_hit <= r_acc || w_edge_hit;
        end
    end

`include "segment_polygon_intersection_macros.svh"

    `SPI_ASSERT_NEXT(a_emit_clears_acc, w_fire && r_job.emit, !r_acc,
        "hit not cleared after result")
    `SPI_ASSERT(a_stall_holds_done,
        (r_state == ST_DONE) && r_job.emit && !w_out_free |-> !w_fire,
        "result dropped while output busy")
    `SPI_ASSERT(a_pop_only_idle, o_q_pop |-> (r_state == ST_IDLE), "edge taken while busy")

endmodule

@@ src/segment_polygon_intersection.sv @@
// Segment against polygon edge test. Each input request carries one polygon
// vertex and, on the first vertex of a polygon, the query segment; tlast marks
// the final vertex, where one result request with the intersects flag in bit 0
// of tdata is returned. The front end takes one vertex per cycle while the
// queue has room and no closing edge is pending, and turns it into edge jobs
// for a two-entry queue; the final vertex of a polygon with more than one
// vertex yields its own edge and the closing edge, and holds the input
// until the closing edge is queued. The back end evaluates the four exact
// orientations of an edge through one pair of signed multipliers, one
// orientation per cycle, so each edge occupies it through load, four product
// steps, last sign and decision. The first vertex of a polygon with more than
// one vertex costs the back end nothing, every later vertex one edge and a
// final vertex of such a polygon two, set by the shared multiplier pair. A
// result waits in an output register while new vertices flow into the queue.
module segment_polygon_intersection
    import spi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // Fields from bit 0 up: seg_start_x, seg_start_z, seg_end_x, seg_end_z,
    // vertex_x, vertex_z, zero padding.
    input  logic [IN_W-1:0]  i_s_axis_tdata,
    // last_vertex
    input  logic             i_s_axis_tlast,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // Fields from bit 0 up: intersects, zero padding.
    output logic [OUT_W-1:0] o_m_axis_tdata
);

    logic w_fq_valid, w_fq_ready;
    t_job w_fq_job;
    logic w_qb_valid, w_qb_pop;
    t_job w_qb_job;

    spi_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tlast  (i_s_axis_tlast),
        .o_q_valid  (w_fq_valid),
        .i_q_ready  (w_fq_ready),
        .o_q_job    (w_fq_job)
    );

    spi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fq_valid),
        .i_job   (w_fq_job),
        .o_ready (w_fq_ready),
        .o_valid (w_qb_valid),
        .i_pop   (w_qb_pop),
        .o_job   (w_qb_job)
    );

    spi_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_qb_valid),
        .o_q_pop    (w_qb_pop),
        .i_q_job    (w_qb_job),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata)
    );

endmodule

@@ bench/tb_segment_polygon_intersection.sv @@
`timescale 1ns / 100ps

module tb_segment_polygon_intersection;
    import spi_pkg::*;

    typedef struct {
        t_coord sx;
        t_coord sz;
        t_coord ex;
        t_coord ez;
        t_coord vx;
        t_coord vz;
        logic   last;
        bit     drain_first;
    } t_vertex_req;

    typedef enum int {RX_STEADY, RX_HALF, RX_SPARSE, RX_MOSTLY} t_rx_mode;

    localparam int HOLD_CYCLES = 400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_axis_tvalid = 1'b0;
    logic o_s_axis_tready;
    logic [IN_W-1:0] i_s_axis_tdata = '0;
    logic i_s_axis_tlast = 1'b0;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0] o_m_axis_tdata;

    segment_polygon_intersection i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    t_vertex_req pending_vertices[$];
    bit          expected_flags[$];
    t_vertex_req drive_req;
    bit          in_taken = 1'b0;
    int          accepted_count = 0;
    int          total_vertices = 0;
    int          result_count = 0;
    int          mismatch_count = 0;
    int          gap_left = 0;
    int          burst_left = 0;

    // Shadow of the block's polygon state.
    t_coord      seg_sx, seg_sz, seg_ex, seg_ez;
    t_coord      first_x, first_z, prev_x, prev_z;
    bit          poly_hit = 1'b0;
    bit          poly_open = 1'b0;

    // Stimulus generator state.
    t_coord      gen_sx, gen_sz, gen_ex, gen_ez;
    bit          gen_first = 1'b1;
    bit          gen_drain = 1'b0;

    function automatic int orient_sign(longint px, longint pz, longint qx, longint qz,
                                       longint rx, longint rz);
        longint cross_val;
        cross_val = (qx - px) * (rz - pz) - (qz - pz) * (rx - px);
        if (cross_val > 0)
            return 1;
        if (cross_val < 0)
            return -1;
        return 0;
    endfunction

    function automatic bit in_bounds(longint px, longint pz, longint qx, longint qz,
                                     longint rx, longint rz);
        longint lox, hix, loz, hiz;
        lox = (px < qx) ? px : qx;
        hix = (px < qx) ? qx : px;
        loz = (pz < qz) ? pz : qz;
        hiz = (pz < qz) ? qz : pz;
        return rx >= lox && rx <= hix && rz >= loz && rz <= hiz;
    endfunction

    function automatic bit edge_touches(t_coord ax, t_coord az, t_coord bx, t_coord bz);
        int d1, d2, d3, d4;
        d1 = orient_sign(ax, az, bx, bz, seg_sx, seg_sz);
        d2 = orient_sign(ax, az, bx, bz, seg_ex, seg_ez);
        d3 = orient_sign(seg_sx, seg_sz, seg_ex, seg_ez, ax, az);
        d4 = orient_sign(seg_sx, seg_sz, seg_ex, seg_ez, bx, bz);
        if (d1 * d2 < 0 && d3 * d4 < 0)
            return 1'b1;
        // Collinear cases: a zero orientation plus the point inside the other's box.
        if (d1 == 0 && in_bounds(ax, az, bx, bz, seg_sx, seg_sz))
            return 1'b1;
        if (d2 == 0 && in_bounds(ax, az, bx, bz, seg_ex, seg_ez))
            return 1'b1;
        if (d3 == 0 && in_bounds(seg_sx, seg_sz, seg_ex, seg_ez, ax, az))
            return 1'b1;
        if (d4 == 0 && in_bounds(seg_sx, seg_sz, seg_ex, seg_ez, bx, bz))
            return 1'b1;
        return 1'b0;
    endfunction

    task automatic predict_vertex(t_vertex_req v);
        if (!poly_open) begin
            seg_sx = v.sx;
            seg_sz = v.sz;
            seg_ex = v.ex;
            seg_ez = v.ez;
            first_x = v.vx;
            first_z = v.vz;
            poly_hit = 1'b0;
            poly_open = 1'b1;
        end else if (edge_touches(prev_x, prev_z, v.vx, v.vz)) begin
            poly_hit = 1'b1;
        end
        prev_x = v.vx;
        prev_z = v.vz;
        if (v.last) begin
            if (edge_touches(v.vx, v.vz, first_x, first_z))
                poly_hit = 1'b1;
            expected_flags.push_back(poly_hit);
            poly_open = 1'b0;
        end
    endtask

    task automatic open_polygon(t_coord sx, t_coord sz, t_coord ex, t_coord ez);
        gen_sx = sx;
        gen_sz = sz;
        gen_ex = ex;
        gen_ez = ez;
        gen_first = 1'b1;
    endtask

    // Later vertices carry junk in the segment fields, which the block must ignore.
    task automatic add_vertex(t_coord vx, t_coord vz, logic last);
        t_vertex_req v;
        v.sx = gen_first ? gen_sx : t_coord'($urandom);
        v.sz = gen_first ? gen_sz : t_coord'($urandom);
        v.ex = gen_first ? gen_ex : t_coord'($urandom);
        v.ez = gen_first ? gen_ez : t_coord'($urandom);
        v.vx = vx;
        v.vz = vz;
        v.last = last;
        v.drain_first = gen_first && gen_drain;
        pending_vertices.push_back(v);
        gen_first = 1'b0;
        gen_drain = 1'b0;
        total_vertices++;
    endtask

    function automatic t_coord pick_coord(int scale);
        case (scale)
            0: return t_coord'($urandom);
            1: return t_coord'(int'($urandom_range(0, 32)) - 16);
            2: begin
                case ($urandom_range(0, 6))
                    0: return t_coord'(-32768);
                    1: return t_coord'(-32767);
                    2: return t_coord'(-1);
                    3: return t_coord'(0);
                    4: return t_coord'(1);
                    5: return t_coord'(32766);
                    default: return t_coord'(32767);
                endcase
            end
            default: return t_coord'(int'($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    task automatic add_random_polygon();
        int     scale, nverts;
        t_coord vx, vz, px, pz;
        scale = $urandom_range(0, 3);
        open_polygon(pick_coord(scale), pick_coord(scale), pick_coord(scale),
                     pick_coord(scale));
        if ($urandom_range(0, 9) == 0) begin
            gen_ex = gen_sx;
            gen_ez = gen_sz;
        end
        nverts = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
        px = 0;
        pz = 0;
        for (int i = 0; i < nverts; i++) begin
            vx = pick_coord(scale);
            vz = pick_coord(scale);
            case ($urandom_range(0, 11))
                0: begin
                    vx = gen_sx;
                    vz = gen_sz;
                end
                1: begin
                    vx = gen_ex;
                    vz = gen_ez;
                end
                2: if (i > 0) begin
                    vx = px;
                    vz = pz;
                end
                default: ;
            endcase
            add_vertex(vx, vz, i == nverts - 1);
            px = vx;
            pz = vz;
        end
    endtask

    // Input acceptance feeds the predictor; result acceptance is checked here.
    always @(posedge i_clk) begin
        bit           want;
        logic [OUT_W-1:0] want_data;
        in_taken = 1'b0;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            in_taken = 1'b1;
            predict_vertex(drive_req);
            accepted_count++;
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            result_count++;
            if (expected_flags.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result request, tdata %0h", $time, o_m_axis_tdata);
            end else begin
                want = expected_flags.pop_front();
                want_data = {{(OUT_W - 1){1'b0}}, want};
                if (o_m_axis_tdata !== want_data) begin
                    mismatch_count++;
                    $display("%0t: result %0d intersects expected %0h got %0h", $time,
                             result_count, want_data, o_m_axis_tdata);
                end
            end
        end
    end

    // Sender: bursts of requests with random gaps, holding each until taken.
    always @(negedge i_clk) begin
        logic next_valid;
        next_valid = i_s_axis_tvalid;
        if (i_rst_n && !(i_s_axis_tvalid && !in_taken)) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_vertices.size() != 0 &&
                         !(pending_vertices[0].drain_first && expected_flags.size() != 0)) begin
                drive_req = pending_vertices.pop_front();
                next_valid = 1'b1;
                i_s_axis_tdata <= {drive_req.vz, drive_req.vx, drive_req.ez, drive_req.ex,
                                   drive_req.sz, drive_req.sx};
                i_s_axis_tlast <= drive_req.last;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
        i_s_axis_tvalid <= next_valid;
    end

    // Receiver: random stall modes, plus long hold-offs that back the block up.
    t_rx_mode rx_mode = RX_STEADY;
    int       rx_mode_left = 0;
    int       hold_left = 0;
    int       hold_mark = 150;

    always @(negedge i_clk) begin
        logic rdy;
        rdy = 1'b0;
        if (hold_left > 0) begin
            hold_left--;
        end else if (accepted_count >= hold_mark) begin
            hold_left = HOLD_CYCLES;
            hold_mark = (hold_mark < 450) ? 450 : 32'h7fff_ffff;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(20, 200);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                RX_STEADY: rdy = 1'b1;
                RX_HALF:   rdy = $urandom_range(0, 1);
                RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
                default:   rdy = ($urandom_range(0, 7) != 0);
            endcase
        end
        i_m_axis_tready <= rdy;
    end

    initial begin
        // Single vertex on the segment, then one just off it.
        open_polygon(0, 0, 10, 10);
        add_vertex(5, 5, 1'b1);
        open_polygon(0, 0, 10, 10);
        add_vertex(5, 6, 1'b1);
        // Two-vertex polygons: crossing and missing.
        open_polygon(-100, 0, 100, 0);
        add_vertex(0, -50, 1'b0);
        add_vertex(0, 50, 1'b1);
        open_polygon(-100, 0, 100, 0);
        add_vertex(0, 10, 1'b0);
        add_vertex(5, 50, 1'b1);
        // Collinear: touching at an endpoint, then a gap of one.
        open_polygon(0, 0, 10, 0);
        add_vertex(10, 0, 1'b0);
        add_vertex(20, 0, 1'b0);
        add_vertex(15, -5, 1'b1);
        open_polygon(0, 0, 10, 0);
        add_vertex(11, 0, 1'b0);
        add_vertex(20, 0, 1'b1);
        // A point segment on an edge, then inside no edge.
        open_polygon(5, 5, 5, 5);
        add_vertex(0, 0, 1'b0);
        add_vertex(10, 10, 1'b0);
        add_vertex(10, 0, 1'b1);
        open_polygon(5, 6, 5, 6);
        add_vertex(0, 0, 1'b0);
        add_vertex(10, 10, 1'b0);
        add_vertex(10, 0, 1'b1);
        // Full-range coordinates, for the widest products.
        open_polygon(-32768, -32768, 32767, 32767);
        add_vertex(-32768, 32767, 1'b0);
        add_vertex(32767, -32768, 1'b0);
        add_vertex(32767, 32767, 1'b1);
        open_polygon(-32768, 32767, -32767, 32767);
        add_vertex(32767, -32768, 1'b0);
        add_vertex(32767, -32767, 1'b0);
        add_vertex(32766, -32768, 1'b1);

        gen_drain = 1'b1;
        while (total_vertices < 650) begin
            if ($urandom_range(0, 29) == 0)
                gen_drain = 1'b1;
            add_random_polygon();
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(negedge i_clk);
        while (accepted_count != total_vertices || expected_flags.size() != 0);
        repeat (64) @(negedge i_clk);

        if (mismatch_count == 0 && expected_flags.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
